// ----- hdl/gbf_pkg.sv -----
// ---------------------------------------------------------------------------
// Bridge finder package
// Shared widths, default sizes, the node-count reset value and the sequencer state type.
// ---------------------------------------------------------------------------
package gbf_pkg;

   localparam int MAX_NODES_DEF   = 64;
   localparam int MAX_ENTRIES_DEF = 256;

   localparam int CFG_W    = 7;
   localparam int FIELD_W  = 6;
   localparam int TDATA_W  = 16;
   localparam int TUSER_W  = 2;

   localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_WR,
      ST_LD_NIL,
      ST_ROOT_RD,
      ST_ROOT_CHK,
      ST_STEP,
      ST_NB,
      ST_NB_NODE,
      ST_PUSH,
      ST_POP_STK,
      ST_POP_NODE,
      ST_FIN
   } state_type;

endpackage

// ----- hdl/gbf_ram.sv -----
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ---------------------------------------------------------------------------
module gbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/gbf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Bridge finder sequencer
// Loads adjacency lists into RAM, then runs an explicit-stack DFS over the
// node table and stack RAMs, emitting bridges through an output register.
// ---------------------------------------------------------------------------
module gbf_ctrl #(
   parameter int MAX_NODES   = gbf_pkg::MAX_NODES_DEF,
   parameter int MAX_ENTRIES = gbf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [$clog2(MAX_NODES):0]  node_lim,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gbf_pkg::FIELD_W-1:0] req_owner,
   input  logic [gbf_pkg::FIELD_W-1:0] req_nbr,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gbf_pkg::FIELD_W-1:0] rsp_from,
   output logic [gbf_pkg::FIELD_W-1:0] rsp_to,
   output logic                        rsp_found,
   output logic                        rsp_ovf,
   output logic                        rsp_last
);
   import gbf_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int LW = $clog2(MAX_ENTRIES + 1);
   localparam int VW = (FIELD_W > NW + 1) ? FIELD_W : NW + 1;
   localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

   typedef struct packed {
      logic [LW-1:0] head;
      logic [LW-1:0] tail;
      logic          vis;
      logic [NW-1:0] disc;
      logic [NW-1:0] low;
   } node_word_type;

   typedef struct packed {
      logic [NW-1:0] node;
      logic [NW-1:0] par;
      logic          hasp;
      logic [LW-1:0] cur;
   } frame_type;

   localparam int NODE_WW = $bits(node_word_type);
   localparam int FRAME_W = $bits(frame_type);

   state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [LW-1:0] ecnt_ff, ecnt_in;
   logic          drop_ff, drop_in;
   logic [NW:0]   time_ff, time_in;
   logic [NW:0]   root_ff, root_in;
   logic [NW-1:0] own_ff, own_in;
   logic [NW-1:0] nbv_ff, nbv_in;
   logic          last_ff, last_in;
   logic [NW-1:0] top_node_ff, top_node_in;
   logic [NW-1:0] top_par_ff, top_par_in;
   logic          top_hasp_ff, top_hasp_in;
   logic [LW-1:0] top_cur_ff, top_cur_in;
   logic [NW-1:0] top_disc_ff, top_disc_in;
   logic [NW-1:0] top_low_ff, top_low_in;
   logic [NW:0]   depth_ff, depth_in;
   logic [NW-1:0] child_ff, child_in;
   logic [NW-1:0] clow_ff, clow_in;
   logic [NW-1:0] nb_ff, nb_in;
   logic [LW-1:0] head_ff, head_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          pend_v_ff, pend_v_in;
   logic [NW-1:0] pend_from_ff, pend_from_in;
   logic [NW-1:0] pend_to_ff, pend_to_in;
   logic          rsp_v_ff, rsp_v_in;
   logic [FIELD_W-1:0] rsp_from_ff, rsp_from_in;
   logic [FIELD_W-1:0] rsp_to_ff, rsp_to_in;
   logic          rsp_found_ff, rsp_found_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          rsp_last_ff, rsp_last_in;

   logic               nbm_we, nbm_re;
   logic [EW-1:0]      nbm_waddr, nbm_raddr;
   logic [NW-1:0]      nbm_wdata, nbm_rdata;
   logic               lnk_we, lnk_re;
   logic [EW-1:0]      lnk_waddr, lnk_raddr;
   logic [LW-1:0]      lnk_wdata, lnk_rdata;
   logic               node_we, node_re;
   logic [NW-1:0]      node_waddr, node_raddr;
   node_word_type      node_wdata, nq;
   logic [NODE_WW-1:0] node_rdata;
   logic               stk_we, stk_re;
   logic [NW-1:0]      stk_waddr, stk_raddr;
   frame_type          stk_wdata, sq;
   logic [FRAME_W-1:0] stk_rdata;

   logic [VW-1:0] own_ext, nbr_ext, lim_ext;
   logic [NW:0]   depth_m1, depth_m2;
   logic [NW-1:0] tdisc;
   logic          out_free, bad, bridge;

   assign nq = node_rdata;
   assign sq = stk_rdata;

   gbf_ram #(.WIDTH(NW), .DEPTH(MAX_ENTRIES)) u_nbr_ram (
      .clock(clock), .wr_en(nbm_we), .wr_addr(nbm_waddr), .wr_data(nbm_wdata),
      .rd_en(nbm_re), .rd_addr(nbm_raddr), .rd_data(nbm_rdata));

   gbf_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_link_ram (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_waddr), .wr_data(lnk_wdata),
      .rd_en(lnk_re), .rd_addr(lnk_raddr), .rd_data(lnk_rdata));

   gbf_ram #(.WIDTH(NODE_WW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_en(node_re), .rd_addr(node_raddr), .rd_data(node_rdata));

   gbf_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_en(stk_re), .rd_addr(stk_raddr), .rd_data(stk_rdata));

   assign own_ext  = VW'(req_owner);
   assign nbr_ext  = VW'(req_nbr);
   assign lim_ext  = VW'(node_lim);
   assign depth_m1 = depth_ff - 1'b1;
   assign depth_m2 = depth_ff - 2'd2;
   assign tdisc    = time_ff[NW-1:0];
   assign out_free = ~rsp_v_ff | rsp_ready;
   assign bad      = (own_ext >= lim_ext) || (nbr_ext >= lim_ext) || (ecnt_ff == NIL);
   assign bridge   = (clow_ff > nq.disc) && (cnt_ff < NW'(MAX_NODES - 1));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_from  = rsp_from_ff;
   assign rsp_to    = rsp_to_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_ovf   = rsp_ovf_ff;
   assign rsp_last  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ecnt_in      = ecnt_ff;
      drop_in      = drop_ff;
      time_in      = time_ff;
      root_in      = root_ff;
      own_in       = own_ff;
      nbv_in       = nbv_ff;
      last_in      = last_ff;
      top_node_in  = top_node_ff;
      top_par_in   = top_par_ff;
      top_hasp_in  = top_hasp_ff;
      top_cur_in   = top_cur_ff;
      top_disc_in  = top_disc_ff;
      top_low_in   = top_low_ff;
      depth_in     = depth_ff;
      child_in     = child_ff;
      clow_in      = clow_ff;
      nb_in        = nb_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_from_in = pend_from_ff;
      pend_to_in   = pend_to_ff;
      rsp_v_in     = rsp_v_ff & ~rsp_ready;
      rsp_from_in  = rsp_from_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      nbm_we = 1'b0; nbm_waddr = ecnt_ff[EW-1:0]; nbm_wdata = nbv_ff;
      nbm_re = 1'b0; nbm_raddr = top_cur_ff[EW-1:0];
      lnk_we = 1'b0; lnk_waddr = ecnt_ff[EW-1:0]; lnk_wdata = NIL;
      lnk_re = 1'b0; lnk_raddr = top_cur_ff[EW-1:0];
      node_we = 1'b0; node_waddr = top_node_ff;
      node_wdata = '{head: NIL, tail: NIL, vis: 1'b1, disc: top_disc_ff, low: top_low_ff};
      node_re = 1'b0; node_raddr = top_node_ff;
      stk_we = 1'b0; stk_waddr = depth_m1[NW-1:0];
      stk_wdata = '{node: top_node_ff, par: top_par_ff, hasp: top_hasp_ff, cur: top_cur_ff};
      stk_re = 1'b0; stk_raddr = depth_m2[NW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = '{head: NIL, tail: NIL, vis: 1'b0, disc: '0, low: '0};
            if (clr_ff == NW'(MAX_NODES - 1)) begin
               ecnt_in   = '0;
               drop_in   = 1'b0;
               time_in   = '0;
               cnt_in    = '0;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               own_in  = own_ext[NW-1:0];
               nbv_in  = nbr_ext[NW-1:0];
               last_in = req_last;
               if (bad) begin
                  drop_in = 1'b1;
                  if (req_last) begin
                     root_in  = '0;
                     state_in = ST_ROOT_RD;
                  end
               end else begin
                  node_re    = 1'b1;
                  node_raddr = own_ext[NW-1:0];
                  state_in   = ST_LD_WR;
               end
            end
         end
         ST_LD_WR: begin
            nbm_we = 1'b1;
            if (nq.tail != NIL) begin
               lnk_we    = 1'b1;
               lnk_waddr = nq.tail[EW-1:0];
               lnk_wdata = ecnt_ff;
            end
            node_we    = 1'b1;
            node_waddr = own_ff;
            node_wdata = '{head: (nq.tail == NIL) ? ecnt_ff : nq.head, tail: ecnt_ff,
                           vis: 1'b0, disc: '0, low: '0};
            state_in   = ST_LD_NIL;
         end
         ST_LD_NIL: begin
            lnk_we  = 1'b1;
            ecnt_in = ecnt_ff + 1'b1;
            if (last_ff) begin
               root_in  = '0;
               state_in = ST_ROOT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT_RD: begin
            if (root_ff >= node_lim) begin
               state_in = ST_FIN;
            end else begin
               node_re    = 1'b1;
               node_raddr = root_ff[NW-1:0];
               state_in   = ST_ROOT_CHK;
            end
         end
         ST_ROOT_CHK: begin
            if (nq.vis) begin
               root_in  = root_ff + 1'b1;
               state_in = ST_ROOT_RD;
            end else begin
               node_we     = 1'b1;
               node_waddr  = root_ff[NW-1:0];
               node_wdata  = '{head: NIL, tail: NIL, vis: 1'b1, disc: tdisc, low: tdisc};
               time_in     = time_ff + 1'b1;
               top_node_in = root_ff[NW-1:0];
               top_par_in  = '0;
               top_hasp_in = 1'b0;
               top_cur_in  = nq.head;
               top_disc_in = tdisc;
               top_low_in  = tdisc;
               depth_in    = (NW+1)'(1);
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (top_cur_ff == NIL) begin
               // list done: persist low, pop to parent or move on to the next root
               node_we  = 1'b1;
               child_in = top_node_ff;
               clow_in  = top_low_ff;
               if (depth_ff == (NW+1)'(1)) begin
                  depth_in = '0;
                  root_in  = root_ff + 1'b1;
                  state_in = ST_ROOT_RD;
               end else begin
                  stk_re   = 1'b1;
                  state_in = ST_POP_STK;
               end
            end else begin
               nbm_re   = 1'b1;
               lnk_re   = 1'b1;
               state_in = ST_NB;
            end
         end
         ST_NB: begin
            top_cur_in = lnk_rdata;
            if ((nbm_rdata >= node_lim[NW-1:0] && node_lim <= (NW+1)'(MAX_NODES - 1)) ||
                (top_hasp_ff && nbm_rdata == top_par_ff)) begin
               state_in = ST_STEP;
            end else begin
               node_re    = 1'b1;
               node_raddr = nbm_rdata;
               nb_in      = nbm_rdata;
               state_in   = ST_NB_NODE;
            end
         end
         ST_NB_NODE: begin
            if (!nq.vis) begin
               if (depth_ff == (NW+1)'(MAX_NODES)) begin
                  state_in = ST_STEP;
               end else begin
                  stk_we   = 1'b1;
                  node_we  = 1'b1;
                  head_in  = nq.head;
                  state_in = ST_PUSH;
               end
            end else begin
               if (nq.disc < top_low_ff) begin
                  top_low_in = nq.disc;
               end
               state_in = ST_STEP;
            end
         end
         ST_PUSH: begin
            node_we     = 1'b1;
            node_waddr  = nb_ff;
            node_wdata  = '{head: NIL, tail: NIL, vis: 1'b1, disc: tdisc, low: tdisc};
            time_in     = time_ff + 1'b1;
            top_node_in = nb_ff;
            top_par_in  = top_node_ff;
            top_hasp_in = 1'b1;
            top_cur_in  = head_ff;
            top_disc_in = tdisc;
            top_low_in  = tdisc;
            depth_in    = depth_ff + 1'b1;
            state_in    = ST_STEP;
         end
         ST_POP_STK: begin
            node_re     = 1'b1;
            node_raddr  = sq.node;
            top_node_in = sq.node;
            top_par_in  = sq.par;
            top_hasp_in = sq.hasp;
            top_cur_in  = sq.cur;
            state_in    = ST_POP_NODE;
         end
         ST_POP_NODE: begin
            // hold here while the previous bridge cannot leave
            if (!(bridge && pend_v_ff && !out_free)) begin
               top_disc_in = nq.disc;
               top_low_in  = (clow_ff < nq.low) ? clow_ff : nq.low;
               depth_in    = depth_m1;
               if (bridge) begin
                  if (pend_v_ff) begin
                     rsp_v_in     = 1'b1;
                     rsp_from_in  = FIELD_W'(pend_from_ff);
                     rsp_to_in    = FIELD_W'(pend_to_ff);
                     rsp_found_in = 1'b1;
                     rsp_ovf_in   = drop_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_from_in = top_node_ff;
                  pend_to_in   = child_ff;
                  cnt_in       = cnt_ff + 1'b1;
               end
               state_in = ST_STEP;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_v_in     = 1'b1;
               rsp_from_in  = pend_v_ff ? FIELD_W'(pend_from_ff) : '0;
               rsp_to_in    = pend_v_ff ? FIELD_W'(pend_to_ff) : '0;
               rsp_found_in = pend_v_ff;
               rsp_ovf_in   = drop_ff;
               rsp_last_in  = 1'b1;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         default: begin
            clr_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         ecnt_ff   <= '0;
         drop_ff   <= 1'b0;
         time_ff   <= '0;
         cnt_ff    <= '0;
         depth_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rsp_v_ff  <= rsp_v_in;
         pend_v_ff <= pend_v_in;
         ecnt_ff   <= ecnt_in;
         drop_ff   <= drop_in;
         time_ff   <= time_in;
         cnt_ff    <= cnt_in;
         depth_ff  <= depth_in;
      end
      root_ff      <= root_in;
      own_ff       <= own_in;
      nbv_ff       <= nbv_in;
      last_ff      <= last_in;
      top_node_ff  <= top_node_in;
      top_par_ff   <= top_par_in;
      top_hasp_ff  <= top_hasp_in;
      top_cur_ff   <= top_cur_in;
      top_disc_ff  <= top_disc_in;
      top_low_ff   <= top_low_in;
      child_ff     <= child_in;
      clow_ff      <= clow_in;
      nb_ff        <= nb_in;
      head_ff      <= head_in;
      pend_from_ff <= pend_from_in;
      pend_to_ff   <= pend_to_in;
      rsp_from_ff  <= rsp_from_in;
      rsp_to_ff    <= rsp_to_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ----- hdl/graph_bridge_finder.sv -----
// ---------------------------------------------------------------------------
// Graph bridge finder
// Collects adjacency entries, then finds every bridge by iterative DFS.
//
//   channel | dir | beat contents
//   req_    | in  | owner_node, neighbor_node; tlast = last_entry
//   rsp_    | out | bridge_from, bridge_to; tuser = found, overflow; tlast = last
//   csr_    | in  | node_count
//
// An accepted entry passes a tail read, a link write and an end mark; no new
// entry is taken until it is stored. The search pace is set by the registered
// reads of the node table, stack and adjacency RAMs.
// After reset and after each run, a sweep clears the node table; req_tready
// stays low during the sweep and the search.
// A stalled rsp_ holds the search only when a second bridge is ready, and
// holds the end of the run until the final beat can be loaded.
// ---------------------------------------------------------------------------
module graph_bridge_finder #(
   parameter int MAX_NODES   = gbf_pkg::MAX_NODES_DEF,
   parameter int MAX_ENTRIES = gbf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [gbf_pkg::TDATA_W-1:0] req_tdata,   // owner_node, neighbor_node
   input  logic                        req_tlast,   // last_entry
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [gbf_pkg::TDATA_W-1:0] rsp_tdata,   // bridge_from, bridge_to
   output logic [gbf_pkg::TUSER_W-1:0] rsp_tuser,   // found, overflow
   output logic                        rsp_tlast,   // last_result
   input  logic                        csr_wr_en,
   input  logic [gbf_pkg::CFG_W-1:0]   csr_wr_data  // node_count
);
   import gbf_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = (NW + 1 > CFG_W) ? NW + 1 : CFG_W;

   logic [CFG_W-1:0]   node_count_ff;
   logic [CW-1:0]      cnt_ext, max_ext, lim_ext;
   logic [NW:0]        node_lim;
   logic [FIELD_W-1:0] from_w, to_w;
   logic               found_w, ovf_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // clamp to the table size
   assign cnt_ext  = CW'(node_count_ff);
   assign max_ext  = CW'(MAX_NODES);
   assign lim_ext  = (cnt_ext > max_ext) ? max_ext : cnt_ext;
   assign node_lim = lim_ext[NW:0];

   gbf_ctrl #(.MAX_NODES(MAX_NODES), .MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .node_lim  (node_lim),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_owner (req_tdata[FIELD_W-1:0]),
      .req_nbr   (req_tdata[2*FIELD_W-1:FIELD_W]),
      .req_last  (req_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_from  (from_w),
      .rsp_to    (to_w),
      .rsp_found (found_w),
      .rsp_ovf   (ovf_w),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(TDATA_W - 2*FIELD_W){1'b0}}, to_w, from_w};
   assign rsp_tuser = {ovf_w, found_w};

endmodule
